// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, off while reset is low.
`define FDL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: check failed");

// Same check, always on, including during reset.
`define FDL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

// ===== src/fdl_pkg.sv =====
`timescale 1ns / 1ps

package fdl_pkg;

  localparam int unsigned AW     = 15;
  localparam int unsigned DEPTH  = 1 << AW;
  localparam int unsigned SW     = 24;
  localparam int unsigned PADDR_W = 4;

  localparam logic [1:0] REG_DELAY_WHOLE    = 2'd0;
  localparam logic [1:0] REG_DELAY_FRACTION = 2'd1;
  localparam logic [1:0] REG_OUTPUT_GAIN    = 2'd2;

  localparam logic [15:0] GAIN_RESET = 16'd4096;

  typedef logic [AW-1:0]        addr_t;
  typedef logic signed [SW-1:0] sample_t;

  typedef struct packed {
    logic    rd_en;
    addr_t   rd_addr;
    logic    wr_en;
    addr_t   wr_addr;
    sample_t wr_data;
  } mem_req_t;

endpackage

// ===== src/fdl_stream_if.sv =====
`timescale 1ns / 1ps

interface fdl_in_if;
  import fdl_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface fdl_out_if;
  import fdl_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== src/fdl_mem.sv =====
`timescale 1ns / 1ps

module fdl_mem
  import fdl_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output sample_t  rdata_o
);

  sample_t mem_q [DEPTH];
  sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/fractional_delay_line.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake            Payload
// sample    in   valid/ready          sample_in  (signed 24)
// result    out  valid/ready          sample_out (signed 24)
// config    in   APB psel/penable     delay_whole, delay_fraction, output_gain
//
// One request runs through six sequencer steps after acceptance (two reads
// of the single-read delay memory, two passes through the shared 25x17
// multiplier, blend and output load), then returns to IDLE. Ready is
// high only in IDLE. A result that is not taken holds the sequencer in its last step.
// Reset is asynchronous; entries of the delay memory not yet written since
// reset are recognized from the write pointer and read as zero.

`include "assert_macros.svh"

module fractional_delay_line
  import fdl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  fdl_in_if.sink             sample_chan_i,
  fdl_out_if.source          result_chan_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,  // wait for a sample
    S_RDN   = 7'b0000010,  // issue near-tap read
    S_RDF   = 7'b0000100,  // take near tap, issue far-tap read
    S_MULF  = 7'b0001000,  // fraction * (far - near); store the sample
    S_BLEND = 7'b0010000,  // round and add to near tap
    S_MULG  = 7'b0100000,  // blend * gain
    S_OUT   = 7'b1000000   // round, saturate, load output register
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [AW-1:0] dwhole_q;
  logic [15:0]   dfrac_q;
  logic [15:0]   gain_q;

  // Delay memory write pointer and a flag set once it has wrapped.
  addr_t wp_q;
  logic  wrapped_q;

  // Datapath registers.
  sample_t            x_q;
  sample_t            near_q;
  sample_t            y_q;
  logic               tap_ok_q;
  logic signed [41:0] prod_q;

  logic    out_valid_q;
  sample_t out_sample_q;

  mem_req_t mem_req;
  sample_t  mem_rdata;

  logic               in_accept;
  logic               out_free;
  logic               bypass;
  logic               cfg_wr;
  addr_t              near_idx;
  addr_t              far_idx;
  addr_t              rd_idx;
  logic               rd_idx_ok;
  sample_t            far_v;
  sample_t            near_v;
  logic signed [24:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [41:0] frac_rnd;
  logic signed [41:0] gain_rnd;
  logic signed [24:0] blend;
  sample_t            sat_v;

  // ------------------------------------------------------------------
  // Configuration port
  // ------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwhole_q <= '0;
      dfrac_q  <= '0;
      gain_q   <= GAIN_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_DELAY_WHOLE:    dwhole_q <= pwdata[AW-1:0];
        REG_DELAY_FRACTION: dfrac_q  <= pwdata[15:0];
        REG_OUTPUT_GAIN:    gain_q   <= pwdata[15:0];
        default: ;  // drop writes outside the register map
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DELAY_WHOLE:    prdata = {{(32-AW){1'b0}}, dwhole_q};
      REG_DELAY_FRACTION: prdata = {16'd0, dfrac_q};
      REG_OUTPUT_GAIN:    prdata = {16'd0, gain_q};
      default:            prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Handshakes
  // ------------------------------------------------------------------
  assign sample_chan_i.ready    = (state_q == S_IDLE);
  assign in_accept              = sample_chan_i.valid && sample_chan_i.ready;
  assign out_free               = !out_valid_q || result_chan_o.ready;
  assign result_chan_o.valid      = out_valid_q;
  assign result_chan_o.sample_out = out_sample_q;

  // Sample passes through the blend unchanged (gain still applies) when no delay at all is set.
  assign bypass = (dwhole_q == '0) && (dfrac_q == '0);

  // ------------------------------------------------------------------
  // Tap addressing: near = wp - whole, far = near - 1, modulo depth.
  // An entry counts as written once the pointer has passed it or wrapped.
  // ------------------------------------------------------------------
  assign near_idx  = wp_q - dwhole_q;
  assign far_idx   = near_idx - addr_t'(1);
  assign rd_idx    = (state_q == S_RDF) ? far_idx : near_idx;
  assign rd_idx_ok = wrapped_q || (rd_idx < wp_q);

  always_comb begin
    mem_req         = '0;
    mem_req.rd_en   = (state_q == S_RDN) || (state_q == S_RDF);
    mem_req.rd_addr = rd_idx;
    mem_req.wr_en   = (state_q == S_MULF);
    mem_req.wr_addr = wp_q;
    mem_req.wr_data = x_q;
  end

  fdl_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Zero whole delay: the current sample stands in for the near tap.
  assign near_v = (dwhole_q == '0) ? x_q : (tap_ok_q ? mem_rdata : '0);
  assign far_v  = tap_ok_q ? mem_rdata : '0;

  // ------------------------------------------------------------------
  // Shared multiplier: fraction pass, then gain pass
  // ------------------------------------------------------------------
  always_comb begin
    if (state_q == S_MULG) begin
      mul_a = {y_q[SW-1], y_q};
      mul_b = {1'b0, gain_q};
    end else begin
      mul_a = {far_v[SW-1], far_v} - {near_q[SW-1], near_q};
      mul_b = {1'b0, dfrac_q};
    end
  end

  // Round to nearest, ties up, then arithmetic shift.
  assign frac_rnd = (prod_q + 42'sd32768) >>> 16;
  assign blend    = {near_q[SW-1], near_q} + frac_rnd[24:0];
  assign gain_rnd = (prod_q + 42'sd2048) >>> 12;

  always_comb begin
    if (gain_rnd > 42'sd8388607) begin
      sat_v = 24'sh7FFFFF;
    end else if (gain_rnd < -42'sd8388608) begin
      sat_v = 24'sh800000;
    end else begin
      sat_v = gain_rnd[SW-1:0];
    end
  end

  // ------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_accept) state_d = S_RDN;
      S_RDN:   state_d = S_RDF;
      S_RDF:   state_d = S_MULF;
      S_MULF:  state_d = S_BLEND;
      S_BLEND: state_d = S_MULG;
      S_MULG:  state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Store the sample only after both taps have been read.
      if (state_q == S_MULF) begin
        wp_q <= wp_q + addr_t'(1);
        if (wp_q == addr_t'(DEPTH - 1)) begin
          wrapped_q <= 1'b1;
        end
      end
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_chan_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q <= sample_chan_i.sample_in;
    end
    if ((state_q == S_RDN) || (state_q == S_RDF)) begin
      tap_ok_q <= rd_idx_ok;
    end
    if (state_q == S_RDF) begin
      near_q <= near_v;
    end
    if ((state_q == S_MULF) || (state_q == S_MULG)) begin
      prod_q <= 42'(mul_a) * 42'(mul_b);
    end
    if (state_q == S_BLEND) begin
      y_q <= bypass ? x_q : blend[SW-1:0];
    end
    if ((state_q == S_OUT) && out_free) begin
      out_sample_q <= sat_v;
    end
  end

  // ------------------------------------------------------------------
  // Checks
  // ------------------------------------------------------------------
  `FDL_ASSERT(a_accept_starts_read, clk_i, rst_ni, in_accept |=> (state_q == S_RDN))
  `FDL_ASSERT(a_wp_step_once, clk_i, rst_ni, (state_q == S_MULF) |=> (wp_q == addr_t'($past(wp_q) + addr_t'(1))))
  `FDL_ASSERT(a_wp_hold_else, clk_i, rst_ni, (state_q != S_MULF) |=> $stable(wp_q))
  `FDL_ASSERT(a_result_from_out, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_OUT))
  `FDL_ASSERT_ALWAYS(a_ready_in_idle, clk_i, sample_chan_i.ready |-> (state_q == S_IDLE))

endmodule
